// ===== rtl/vcde_pkg.sv =====
// Package for the voxel cube draw engine: command codes, sequencer states,
// row-operation types and helper functions. No dependencies.
package vcde_pkg;

  localparam int EdgeLen  = 8;
  localparam int RowCount = EdgeLen * EdgeLen;
  localparam int RowAw    = $clog2(RowCount);
  localparam int CoordW   = $clog2(EdgeLen);

  typedef logic [EdgeLen-1:0] row_t;
  typedef logic [RowAw-1:0]   raddr_t;
  typedef logic [CoordW-1:0]  coord_t;

  typedef enum logic [4:0] {
    ACT_SET      = 5'd0,
    ACT_CLEAR    = 5'd1,
    ACT_FLIP     = 5'd2,
    ACT_GET      = 5'd3,
    ACT_LEVEL    = 5'd4,
    ACT_PLANE_ON = 5'd5,
    ACT_PLANE_OFF= 5'd6,
    ACT_FILL     = 5'd7,
    ACT_BOX_FILL = 5'd8,
    ACT_BOX_WALL = 5'd9,
    ACT_BOX_WIRE = 5'd10,
    ACT_SHIFT    = 5'd11,
    ACT_MIRROR_X = 5'd12,
    ACT_MIRROR_Y = 5'd13,
    ACT_MIRROR_Z = 5'd14,
    ACT_SC_SET   = 5'd15,
    ACT_SC_CLEAR = 5'd16,
    ACT_SC_FILL  = 5'd17,
    ACT_COPY     = 5'd18
  } action_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SNAP,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } state_t;

  // Per-row operation applied by the shared row unit.
  typedef enum logic [2:0] {
    OP_KEEP,
    OP_OR,
    OP_ANDN,
    OP_XOR,
    OP_LOAD,
    OP_SHL,
    OP_SHR,
    OP_REV
  } rowop_t;

  typedef struct packed {
    rowop_t op;
    row_t   mask;
  } rowcmd_t;

  function automatic row_t bit_of(input coord_t x);
    row_t r;
    r = '0;
    r[x] = 1'b1;
    return r;
  endfunction

  function automatic row_t span(input coord_t lo, input coord_t hi);
    row_t r;
    r = '0;
    for (int k = 0; k < EdgeLen; k++) begin
      r[k] = (coord_t'(k) >= lo) && (coord_t'(k) <= hi);
    end
    return r;
  endfunction

  function automatic logic in_range(input logic signed [4:0] v);
    return (v >= 0) && (v < EdgeLen);
  endfunction

endpackage

// ===== rtl/vcde_row_unit.sv =====
// Shared row unit of the voxel cube draw engine: applies one row operation
// to one row byte. Depends on vcde_pkg.
module vcde_row_unit import vcde_pkg::*; (
  input  rowcmd_t cmd,
  input  row_t    din,
  input  row_t    load,
  output row_t    dout
);

  always_comb begin
    case (cmd.op)
      OP_KEEP: dout = din;
      OP_OR:   dout = din | cmd.mask;
      OP_ANDN: dout = din & ~cmd.mask;
      OP_XOR:  dout = din ^ cmd.mask;
      OP_LOAD: dout = load;
      OP_SHL:  dout = {din[EdgeLen-2:0], 1'b0};
      OP_SHR:  dout = {1'b0, din[EdgeLen-1:1]};
      OP_REV:  dout = {<<{din}};
      default: dout = din;
    endcase
  end

endmodule

// ===== rtl/voxel_cube_draw_engine.sv =====
// Top level of the voxel cube draw engine: command sequencer, display, scratch and
// snapshot row memories. Depends on vcde_pkg and vcde_row_unit.
//
// Usage: after reset the engine sweeps both stores clear with busy high. Each
// command is taken when start is high and busy low, and gives one result
// strobe with voxel_bit. A command walks all 64 rows through a single
// read-modify-write row unit, reading and then writing each row, after a
// snapshot pass of the display store for shift and y or z mirror commands.
// The result cannot be stalled; take it in the cycle that done is high.
module voxel_cube_draw_engine import vcde_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  input  logic [4:0]        action,
  input  logic signed [4:0] first_x,
  input  logic signed [4:0] first_y,
  input  logic signed [4:0] first_z,
  input  logic signed [4:0] second_x,
  input  logic signed [4:0] second_y,
  input  logic signed [4:0] second_z,
  input  logic [1:0]        axis,
  input  logic              direction,
  input  logic [7:0]        pattern,
  input  logic signed [4:0] plane_index,
  input  logic              level,
  output logic              voxel_bit
);

  row_t disp_mem [RowCount];
  row_t scr_mem  [RowCount];
  row_t snap_mem [RowCount];

  state_t state, state_next;
  logic [RowAw:0] cnt, cnt_next;

  // captured request
  logic [4:0] act;
  coord_t px, py, pz, lx, hx, ly, hy, lz, hz, pp;
  logic pt_ok, box_ok, pl_ok, dir, lvl;
  axis_t ax;
  row_t pat;

  raddr_t ra;
  coord_t ry, rz;
  row_t disp_q, scr_q, snap_q, wr_row, load_row;
  rowcmd_t cmd;
  logic get_bit;
  logic snap_we, disp_we, scr_we;
  raddr_t snap_ra;
  raddr_t snap_wa;
  logic snap_wr;

  assign ra = cnt[RowAw-1:0];
  assign ry = ra[CoordW-1:0];
  assign rz = ra[RowAw-1:CoordW];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      act    <= action;
      px     <= first_x[CoordW-1:0];
      py     <= first_y[CoordW-1:0];
      pz     <= first_z[CoordW-1:0];
      lx     <= (first_x < second_x) ? first_x[CoordW-1:0] : second_x[CoordW-1:0];
      hx     <= (first_x < second_x) ? second_x[CoordW-1:0] : first_x[CoordW-1:0];
      ly     <= (first_y < second_y) ? first_y[CoordW-1:0] : second_y[CoordW-1:0];
      hy     <= (first_y < second_y) ? second_y[CoordW-1:0] : first_y[CoordW-1:0];
      lz     <= (first_z < second_z) ? first_z[CoordW-1:0] : second_z[CoordW-1:0];
      hz     <= (first_z < second_z) ? second_z[CoordW-1:0] : first_z[CoordW-1:0];
      pt_ok  <= in_range(first_x) && in_range(first_y) && in_range(first_z);
      box_ok <= in_range(first_x) && in_range(first_y) && in_range(first_z) &&
                in_range(second_x) && in_range(second_y) && in_range(second_z);
      pl_ok  <= in_range(plane_index);
      pp     <= plane_index[CoordW-1:0];
      ax     <= axis_t'(axis);
      dir    <= direction;
      lvl    <= level;
      pat    <= pattern;
    end
  end

  // snapshot source row for shift and mirror along y or z
  always_comb begin
    snap_ra = ra;
    case (act)
      ACT_MIRROR_Y: snap_ra = {rz, coord_t'(EdgeLen - 1) - ry};
      ACT_MIRROR_Z: snap_ra = {coord_t'(EdgeLen - 1) - rz, ry};
      ACT_SHIFT: begin
        if (ax == AXIS_Y) snap_ra = {rz, dir ? ry - 1'b1 : ry + 1'b1};
        if (ax == AXIS_Z) snap_ra = {dir ? rz - 1'b1 : rz + 1'b1, ry};
      end
      default: snap_ra = ra;
    endcase
  end

  // snapshot writes the registered display row in the cycle after its read
  always_ff @(posedge clk) begin
    disp_q  <= disp_mem[ra];
    scr_q   <= scr_mem[ra];
    snap_q  <= snap_mem[snap_ra];
    snap_wa <= ra;
    if (snap_wr) snap_mem[snap_wa] <= disp_q;
  end

  always_ff @(posedge clk) begin
    if (rst) snap_wr <= 1'b0;
    else snap_wr <= snap_we;
  end

  // reset sweep writes zero to both stores
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR && !cnt[RowAw]) begin
      disp_mem[ra] <= '0;
      scr_mem[ra]  <= '0;
    end else begin
      if (disp_we) disp_mem[ra] <= wr_row;
      if (scr_we)  scr_mem[ra]  <= wr_row;
    end
  end

  // per-row operation for the current command
  always_comb begin
    logic hit, ybox, zbox, yedge, zedge, edge_src;
    hit   = pt_ok && (ry == py) && (rz == pz);
    ybox  = (ry >= ly) && (ry <= hy);
    zbox  = (rz >= lz) && (rz <= hz);
    yedge = (ry == ly) || (ry == hy);
    zedge = (rz == lz) || (rz == hz);
    edge_src = 1'b1;
    load_row = '0;
    cmd = '{op: OP_KEEP, mask: '0};
    case (act)
      ACT_SET, ACT_SC_SET: if (hit) cmd = '{op: OP_OR, mask: bit_of(px)};
      ACT_CLEAR, ACT_SC_CLEAR: if (hit) cmd = '{op: OP_ANDN, mask: bit_of(px)};
      ACT_FLIP: if (hit) cmd = '{op: OP_XOR, mask: bit_of(px)};
      ACT_LEVEL: if (hit) cmd = '{op: lvl ? OP_OR : OP_ANDN, mask: bit_of(px)};
      ACT_PLANE_ON, ACT_PLANE_OFF: begin
        if (pl_ok) begin
          if (ax == AXIS_X)
            cmd = '{op: (act == ACT_PLANE_ON) ? OP_OR : OP_ANDN, mask: bit_of(pp)};
          else if ((ax == AXIS_Y && ry == pp) || (ax == AXIS_Z && rz == pp))
            cmd = '{op: OP_LOAD, mask: '0};
        end
      end
      ACT_FILL, ACT_SC_FILL, ACT_COPY: cmd = '{op: OP_LOAD, mask: '0};
      ACT_BOX_FILL: if (box_ok && ybox && zbox) cmd = '{op: OP_OR, mask: span(lx, hx)};
      ACT_BOX_WALL: begin
        if (box_ok && ybox && zbox) begin
          if (yedge || zedge) cmd = '{op: OP_LOAD, mask: '0};
          else cmd = '{op: OP_OR, mask: bit_of(lx) | bit_of(hx)};
        end
      end
      ACT_BOX_WIRE: begin
        if (box_ok) begin
          if (yedge && zedge) cmd = '{op: OP_LOAD, mask: '0};
          else if ((ybox && zedge) || (zbox && yedge))
            cmd = '{op: OP_OR, mask: bit_of(lx) | bit_of(hx)};
        end
      end
      ACT_SHIFT: begin
        if (ax == AXIS_X) cmd = '{op: dir ? OP_SHL : OP_SHR, mask: '0};
        else if (ax != AXIS_NONE) cmd = '{op: OP_LOAD, mask: '0};
      end
      ACT_MIRROR_X: cmd = '{op: OP_REV, mask: '0};
      ACT_MIRROR_Y, ACT_MIRROR_Z: cmd = '{op: OP_LOAD, mask: '0};
      default: cmd = '{op: OP_KEEP, mask: '0};
    endcase
    case (act)
      ACT_PLANE_ON:  load_row = '1;
      ACT_FILL, ACT_SC_FILL: load_row = pat;
      ACT_COPY:      load_row = scr_q;
      ACT_BOX_WALL, ACT_BOX_WIRE: load_row = span(lx, hx);
      ACT_MIRROR_Y, ACT_MIRROR_Z: load_row = snap_q;
      ACT_SHIFT: begin
        if (ax == AXIS_Y)
          edge_src = dir ? (ry != '0) : (ry != coord_t'(EdgeLen - 1));
        else
          edge_src = dir ? (rz != '0) : (rz != coord_t'(EdgeLen - 1));
        load_row = edge_src ? snap_q : '0;
      end
      default: load_row = '0;
    endcase
  end

  logic sc_target;
  row_t unit_in;
  assign sc_target = (act == ACT_SC_SET) || (act == ACT_SC_CLEAR) || (act == ACT_SC_FILL);
  assign unit_in = sc_target ? scr_q : disp_q;

  vcde_row_unit u_row (
    .cmd  (cmd),
    .din  (unit_in),
    .load (load_row),
    .dout (wr_row)
  );

  always_ff @(posedge clk) begin
    if (rst || state == ST_IDLE) get_bit <= 1'b0;
    else if (state == ST_WRITE && act == ACT_GET && pt_ok && ry == py && rz == pz)
      get_bit <= disp_q[px];
  end

  always_comb begin
    logic snap_needed;
    state_next = state;
    cnt_next   = cnt;
    snap_we = 1'b0;
    disp_we = 1'b0;
    scr_we  = 1'b0;
    busy    = 1'b1;
    done    = 1'b0;
    snap_needed = (action == ACT_MIRROR_Y) || (action == ACT_MIRROR_Z) ||
                  (action == ACT_SHIFT);
    case (state)
      ST_CLEAR: begin
        // sweep both stores to zero, one row a cycle
        cnt_next = cnt + 1'b1;
        if (cnt[RowAw]) begin
          state_next = ST_IDLE;
          cnt_next = '0;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        cnt_next = '0;
        if (start) state_next = snap_needed ? ST_SNAP : ST_READ;
      end
      ST_SNAP: begin
        // a final step with the snapshot write off lets the last row land in the snapshot
        snap_we = !cnt[RowAw];
        cnt_next = cnt + 1'b1;
        if (cnt[RowAw]) begin
          cnt_next = '0;
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_WRITE;
      ST_WRITE: begin
        disp_we = !sc_target && (cmd.op != OP_KEEP);
        scr_we  = sc_target && (cmd.op != OP_KEEP);
        cnt_next = cnt + 1'b1;
        state_next = ST_READ;
        if (cnt == (RowAw+1)'(RowCount - 1)) begin
          cnt_next = '0;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        done = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign voxel_bit = done & get_bit;

`ifndef SYNTHESIS
  a_busy_done: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("not idle after done");
  a_bit_only_done: assert property (@(posedge clk) disable iff (rst)
    voxel_bit |-> done) else $error("voxel_bit outside done");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");
`endif

endmodule

// ===== sim/voxel_cube_draw_engine_tb.sv =====
// Self-checking testbench for voxel_cube_draw_engine: drives commands, predicts the cube stores
// and checks every voxel_bit result. Depends on vcde_pkg and the engine RTL.
module voxel_cube_draw_engine_tb;
  import vcde_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 2_000_000;
  localparam int RandomCount = 1200;

  typedef struct {
    logic [4:0]        action;
    logic signed [4:0] first_x, first_y, first_z;
    logic signed [4:0] second_x, second_y, second_z;
    logic [1:0]        axis;
    logic              direction;
    logic [7:0]        pattern;
    logic signed [4:0] plane_index;
    logic              level;
  } cmd_t;

  class cube_scoreboard;
    logic [7:0] disp [64];
    logic [7:0] scr [64];
    logic       voxel_q [$];
    int         errors;
    int         checked;
    int         ones;

    function new();
      foreach (disp[i]) begin
        disp[i] = '0;
        scr[i] = '0;
      end
      errors = 0;
      checked = 0;
      ones = 0;
    endfunction

    function bit ok(int v);
      return v >= 0 && v < EdgeLen;
    endfunction

    function int row_ix(int y, int z);
      return z * EdgeLen + y;
    endfunction

    function logic [7:0] span_of(int lo, int hi);
      logic [7:0] r;
      r = '0;
      for (int k = lo; k <= hi; k++) r[k] = 1'b1;
      return r;
    endfunction

    function void draw_box(logic [4:0] kind, int x1, int y1, int z1, int x2, int y2, int z2);
      logic [7:0] line;
      int t;
      if (!(ok(x1) && ok(y1) && ok(z1) && ok(x2) && ok(y2) && ok(z2))) return;
      if (x1 > x2) begin t = x1; x1 = x2; x2 = t; end
      if (y1 > y2) begin t = y1; y1 = y2; y2 = t; end
      if (z1 > z2) begin t = z1; z1 = z2; z2 = t; end
      line = span_of(x1, x2);
      if (kind == ACT_BOX_FILL) begin
        for (int z = z1; z <= z2; z++)
          for (int y = y1; y <= y2; y++) disp[row_ix(y, z)] |= line;
      end else if (kind == ACT_BOX_WALL) begin
        for (int z = z1; z <= z2; z++)
          for (int y = y1; y <= y2; y++) begin
            if (y == y1 || y == y2 || z == z1 || z == z2) disp[row_ix(y, z)] = line;
            else disp[row_ix(y, z)] |= (8'(1) << x1) | (8'(1) << x2);
          end
      end else begin
        // lines along x overwrite their rows, then lines along y and z are OR-ed in
        disp[row_ix(y1, z1)] = line;
        disp[row_ix(y2, z1)] = line;
        disp[row_ix(y1, z2)] = line;
        disp[row_ix(y2, z2)] = line;
        for (int y = y1; y <= y2; y++) begin
          disp[row_ix(y, z1)] |= (8'(1) << x1) | (8'(1) << x2);
          disp[row_ix(y, z2)] |= (8'(1) << x1) | (8'(1) << x2);
        end
        for (int z = z1; z <= z2; z++) begin
          disp[row_ix(y1, z)] |= (8'(1) << x1) | (8'(1) << x2);
          disp[row_ix(y2, z)] |= (8'(1) << x1) | (8'(1) << x2);
        end
      end
    endfunction

    function void note(cmd_t c);
      int x, y, z, p, sy, sz, ri;
      bit pt;
      logic [7:0] old [64];
      logic [7:0] b;
      logic [7:0] rv;
      logic bitv;
      x = c.first_x;
      y = c.first_y;
      z = c.first_z;
      p = c.plane_index;
      pt = ok(x) && ok(y) && ok(z);
      ri = pt ? row_ix(y, z) : 0;
      b = pt ? 8'(1) << x : 8'h00;
      bitv = 1'b0;
      old = disp;
      case (c.action)
        ACT_SET:      if (pt) disp[ri] |= b;
        ACT_CLEAR:    if (pt) disp[ri] &= ~b;
        ACT_FLIP:     if (pt) disp[ri] ^= b;
        ACT_GET:      if (pt) bitv = |(disp[ri] & b);
        ACT_LEVEL:    if (pt) disp[ri] = c.level ? (disp[ri] | b) : (disp[ri] & ~b);
        ACT_PLANE_ON, ACT_PLANE_OFF: begin
          if (ok(p))
            for (int a = 0; a < EdgeLen; a++)
              for (int k = 0; k < EdgeLen; k++) begin
                if (c.axis == AXIS_X) begin
                  if (c.action == ACT_PLANE_ON) disp[row_ix(a, k)][p] = 1'b1;
                  else disp[row_ix(a, k)][p] = 1'b0;
                end else if (c.axis == AXIS_Y && k == 0) begin
                  disp[row_ix(p, a)] = (c.action == ACT_PLANE_ON) ? 8'hff : 8'h00;
                end else if (c.axis == AXIS_Z && k == 0) begin
                  disp[row_ix(a, p)] = (c.action == ACT_PLANE_ON) ? 8'hff : 8'h00;
                end
              end
        end
        ACT_FILL:     foreach (disp[i]) disp[i] = c.pattern;
        ACT_BOX_FILL, ACT_BOX_WALL, ACT_BOX_WIRE:
          draw_box(c.action, x, y, z, c.second_x, c.second_y, c.second_z);
        ACT_SHIFT: begin
          for (int zz = 0; zz < EdgeLen; zz++)
            for (int yy = 0; yy < EdgeLen; yy++) begin
              if (c.axis == AXIS_X) begin
                disp[row_ix(yy, zz)] = c.direction ? old[row_ix(yy, zz)] << 1
                                                   : old[row_ix(yy, zz)] >> 1;
              end else if (c.axis == AXIS_Y || c.axis == AXIS_Z) begin
                sy = yy;
                sz = zz;
                if (c.axis == AXIS_Y) sy = c.direction ? yy - 1 : yy + 1;
                else sz = c.direction ? zz - 1 : zz + 1;
                disp[row_ix(yy, zz)] = (ok(sy) && ok(sz)) ? old[row_ix(sy, sz)] : 8'h00;
              end
            end
        end
        ACT_MIRROR_X: begin
          foreach (disp[i]) begin
            for (int k = 0; k < 8; k++) rv[7-k] = old[i][k];
            disp[i] = rv;
          end
        end
        ACT_MIRROR_Y:
          for (int a = 0; a < EdgeLen; a++)
            for (int k = 0; k < EdgeLen; k++) disp[row_ix(7 - k, a)] = old[row_ix(k, a)];
        ACT_MIRROR_Z:
          for (int a = 0; a < EdgeLen; a++)
            for (int k = 0; k < EdgeLen; k++) disp[row_ix(k, 7 - a)] = old[row_ix(k, a)];
        ACT_SC_SET:   if (pt) scr[ri] |= b;
        ACT_SC_CLEAR: if (pt) scr[ri] &= ~b;
        ACT_SC_FILL:  foreach (scr[i]) scr[i] = c.pattern;
        ACT_COPY:     disp = scr;
        default: ;
      endcase
      voxel_q.push_back(bitv);
    endfunction

    function void check(logic got);
      logic want;
      if (voxel_q.size() == 0) begin
        $error("unexpected result: voxel_bit=%0b with no request pending", got);
        errors++;
        return;
      end
      want = voxel_q.pop_front();
      checked++;
      if (want) ones++;
      if (got !== want) begin
        $error("voxel_bit mismatch: expected %0b, actual %0b", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, done;
  logic [4:0] action;
  logic signed [4:0] first_x, first_y, first_z, second_x, second_y, second_z, plane_index;
  logic [1:0] axis;
  logic direction, level, voxel_bit;
  logic [7:0] pattern;
  int cycles;
  cube_scoreboard sb;

  voxel_cube_draw_engine dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) if (!rst && done) sb.check(voxel_bit);

  function automatic cmd_t mk(logic [4:0] act, int x = 0, int y = 0, int z = 0, int x2 = 0,
                              int y2 = 0, int z2 = 0, int ax = 0, int dir = 0,
                              int pat = 0, int pidx = 0, int lvl = 0);
    cmd_t c;
    c.action = act;
    c.first_x = 5'(x);
    c.first_y = 5'(y);
    c.first_z = 5'(z);
    c.second_x = 5'(x2);
    c.second_y = 5'(y2);
    c.second_z = 5'(z2);
    c.axis = 2'(ax);
    c.direction = 1'(dir);
    c.pattern = 8'(pat);
    c.plane_index = 5'(pidx);
    c.level = 1'(lvl);
    return c;
  endfunction

  // mostly inside the cube, sometimes any 5-bit value
  function automatic int rand_coord(int pct_in);
    if ($urandom_range(99) < pct_in) return $urandom_range(7);
    return $signed(5'($urandom));
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int r;
    int pin;
    r = $urandom_range(99);
    if (r < 20) c.action = ACT_GET;
    else if (r < 35) c.action = 5'($urandom_range(2)) + ACT_SET;
    else if (r < 95) c.action = 5'($urandom_range(18));
    else c.action = 5'($urandom);
    pin = (c.action inside {ACT_BOX_FILL, ACT_BOX_WALL, ACT_BOX_WIRE}) ? 95 : 85;
    c.first_x = 5'(rand_coord(pin));
    c.first_y = 5'(rand_coord(pin));
    c.first_z = 5'(rand_coord(pin));
    c.second_x = 5'(rand_coord(pin));
    c.second_y = 5'(rand_coord(pin));
    c.second_z = 5'(rand_coord(pin));
    c.axis = ($urandom_range(9) == 0) ? AXIS_NONE : 2'($urandom_range(2));
    c.direction = 1'($urandom);
    c.pattern = 8'($urandom);
    c.plane_index = 5'(rand_coord(85));
    c.level = 1'($urandom);
    return c;
  endfunction

  // hold the request until the engine takes it; start stays high afterwards
  task automatic send(cmd_t c);
    action <= c.action;
    first_x <= c.first_x;
    first_y <= c.first_y;
    first_z <= c.first_z;
    second_x <= c.second_x;
    second_y <= c.second_y;
    second_z <= c.second_z;
    axis <= c.axis;
    direction <= c.direction;
    pattern <= c.pattern;
    plane_index <= c.plane_index;
    level <= c.level;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note(c);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 4)) @(posedge clk);
  endtask

  initial begin
    cmd_t dir_list [$];
    sb = new();
    cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    action = '0;
    first_x = '0;
    first_y = '0;
    first_z = '0;
    second_x = '0;
    second_y = '0;
    second_z = '0;
    axis = '0;
    direction = 1'b0;
    pattern = '0;
    plane_index = '0;
    level = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    dir_list = '{
      mk(ACT_GET, 7, 7, 7), mk(ACT_SET, 0, 0, 0), mk(ACT_SET, 7, 7, 7),
      mk(ACT_GET, 7, 7, 7), mk(ACT_SET, -8, 3, 3), mk(ACT_GET, 15, 0, 0),
      mk(ACT_GET, -1, 0, 0), mk(ACT_FLIP, 7, 7, 7), mk(ACT_LEVEL, 3, 4, 5, .lvl(1)),
      mk(ACT_CLEAR, 0, 0, 0), mk(ACT_PLANE_ON, .ax(0), .pidx(7)),
      mk(ACT_PLANE_ON, .ax(1), .pidx(0)), mk(ACT_PLANE_OFF, .ax(2), .pidx(15)),
      mk(ACT_PLANE_ON, .ax(3), .pidx(2)), mk(ACT_BOX_FILL, 6, 5, 7, 1, 0, 2),
      mk(ACT_BOX_WALL, 0, 0, 0, 7, 7, 7), mk(ACT_BOX_WIRE, 7, 1, 6, 2, 6, 0),
      mk(ACT_BOX_FILL, 0, 0, 0, 8, 3, 3), mk(ACT_SHIFT, .ax(0), .dir(1)),
      mk(ACT_SHIFT, .ax(3), .dir(0)), mk(ACT_MIRROR_X), mk(ACT_MIRROR_Y), mk(ACT_MIRROR_Z),
      mk(ACT_SC_FILL, .pat(8'ha5)), mk(ACT_SC_SET, 7, 0, 7), mk(ACT_SC_CLEAR, 0, 0, 0),
      mk(ACT_COPY), mk(ACT_FILL, .pat(8'hff)), mk(5'd19), mk(5'd31)
    };
    foreach (dir_list[i]) begin
      send(dir_list[i]);
      if ($urandom_range(2) == 0) idle_burst();
    end

    for (int n = 0; n < RandomCount; n++) begin
      send(rand_cmd());
      if (n < RandomCount - 200 && $urandom_range(2) == 0) idle_burst();
    end
    start <= 1'b0;

    while (sb.voxel_q.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);

    $display("Checked %0d results (%0d get answers of 1) over directed and random commands.",
             sb.checked, sb.ones);
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
